// File: hw/rtl/rtpfua_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes for the RTP FU-A packetizer.
package rtpfua_pkg;

  // Block parameter defaults
  localparam int unsigned MAX_FRAGMENTS_DEF      = 64;
  localparam int unsigned MAX_PACKET_PAYLOAD_DEF = 1500;

  // Field widths
  localparam int unsigned LEAD_W  = 40;
  localparam int unsigned BLEN_W  = 17;
  localparam int unsigned TUS_W   = 48;
  localparam int unsigned PLEN_W  = 11;
  localparam int unsigned DSCP_W  = 6;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Timestamp conversion: (us * 9) / 100, four 13-bit quotient digits
  localparam int unsigned TS_NUM_W    = TUS_W + 4;
  localparam int unsigned TS_DIVISOR  = 100;
  localparam int unsigned TS_REM_W    = 7;
  localparam int unsigned TS_DIGIT_W  = 13;
  localparam int unsigned TS_DIGITS   = TS_NUM_W / TS_DIGIT_W;
  // Reciprocal of the divisor: ceil(2^27 / 100), exact for partial dividends < 2^20
  localparam int unsigned TS_RECIP_W  = 21;
  localparam int unsigned TS_RECIP    = 1342178;
  localparam int unsigned TS_RECIP_SH = 27;

  // Payload limit floor
  localparam int unsigned MIN_PAYLOAD = 64;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [1:0] REG_DSCP_REF    = 2'd1;
  localparam logic [1:0] REG_DSCP_OTHER  = 2'd2;

  // Register reset values
  localparam logic [PLEN_W-1:0] MAX_PAYLOAD_RST = 11'd1200;
  localparam logic [DSCP_W-1:0] DSCP_REF_RST    = 6'd36;
  localparam logic [DSCP_W-1:0] DSCP_OTHER_RST  = 6'd34;

  // NAL types
  localparam logic [4:0] NAL_NONIDR = 5'd1;
  localparam logic [4:0] NAL_IDR    = 5'd5;
  localparam logic [4:0] NAL_SPS    = 5'd7;
  localparam logic [4:0] NAL_PPS    = 5'd8;
  localparam logic [4:0] NAL_FU_A   = 5'd28;

  // Sent-type marks
  localparam logic [2:0] MARK_SPS = 3'b001;
  localparam logic [2:0] MARK_PPS = 3'b010;
  localparam logic [2:0] MARK_IDR = 3'b100;

  // FU header flags
  localparam logic [7:0] FU_START = 8'h80;
  localparam logic [7:0] FU_END   = 8'h40;

  // Divider status toward the sequencer
  typedef struct packed {
    logic            done;
    logic [TS_W-1:0] quotient;
  } div_status_t;

endpackage

// File: hw/rtl/rtpfua_tsdiv.sv
`timescale 1ns / 1ps
// Digit-at-a-time divider by 100 for the RTP timestamp, one 13-bit digit per cycle.
module rtpfua_tsdiv (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rtpfua_pkg::TS_NUM_W-1:0]  dividend_i,
  output rtpfua_pkg::div_status_t          status_o
);

  localparam int unsigned CntW  = $clog2(rtpfua_pkg::TS_DIGITS);
  localparam int unsigned NumW  = rtpfua_pkg::TS_NUM_W;
  localparam int unsigned DigW  = rtpfua_pkg::TS_DIGIT_W;
  localparam int unsigned RemW  = rtpfua_pkg::TS_REM_W;
  localparam int unsigned PartW = RemW + DigW;
  localparam int unsigned MulW  = PartW + rtpfua_pkg::TS_RECIP_W;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [NumW-1:0]     num_q, num_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [PartW-1:0]    part;
  logic [MulW-1:0]     scaled;
  logic [DigW-1:0]     digit;
  logic [PartW-1:0]    back;
  logic                last_step;

  // Partial dividend: running remainder joined with the next dividend digit
  assign part      = {rem_q, num_q[NumW-1 -: DigW]};
  assign scaled    = MulW'(part) * MulW'(rtpfua_pkg::TS_RECIP);
  assign digit     = scaled[rtpfua_pkg::TS_RECIP_SH +: DigW];
  assign back      = part - PartW'(digit) * PartW'(rtpfua_pkg::TS_DIVISOR);
  assign last_step = cnt_q == CntW'(rtpfua_pkg::TS_DIGITS - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift one quotient digit in, keep the remainder
      rem_d = back[RemW-1:0];
      num_d = {num_q[NumW-DigW-1:0], digit};
      cnt_d = cnt_q + CntW'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign status_o.done     = done_q;
  assign status_o.quotient = num_q[rtpfua_pkg::TS_W-1:0];

endmodule

// File: hw/rtl/h264_rtp_fua_packetizer_top.sv
`timescale 1ns / 1ps
// H.264 RTP packetizer top level: NAL gating, FU-A fragmentation, APB registers.
// The first result follows the timestamp divider (one 13-bit quotient digit per cycle).
// Throughput: one item in flight; after the divider, one result per cycle while the output
//   is not held by out_ready_i. Dropped NALs are accepted without entering the divider.
// Reset: asynchronous, active low; clears sent-type marks and restores registers.
module h264_rtp_fua_packetizer_top #(
  parameter int unsigned MAX_FRAGMENTS      = rtpfua_pkg::MAX_FRAGMENTS_DEF,
  parameter int unsigned MAX_PACKET_PAYLOAD = rtpfua_pkg::MAX_PACKET_PAYLOAD_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rtpfua_pkg::ADDR_W-1:0]     paddr,
  input  logic [rtpfua_pkg::DATA_W-1:0]     pwdata,
  output logic [rtpfua_pkg::DATA_W-1:0]     prdata,
  output logic                              pready,
  // NAL descriptor input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rtpfua_pkg::LEAD_W-1:0]     lead_bytes_i,
  input  logic [rtpfua_pkg::BLEN_W-1:0]     buffer_len_i,
  input  logic [rtpfua_pkg::TUS_W-1:0]      timestamp_us_i,
  input  logic                              end_of_frame_i,
  // Packet descriptor output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              status_o,
  output logic [rtpfua_pkg::BLEN_W-1:0]     payload_offset_o,
  output logic [rtpfua_pkg::PLEN_W-1:0]     payload_len_o,
  output logic                              has_fu_header_o,
  output logic [7:0]                        fu_indicator_o,
  output logic [7:0]                        fu_header_o,
  output logic                              marker_o,
  output logic [rtpfua_pkg::TS_W-1:0]       rtp_timestamp_o,
  output logic [rtpfua_pkg::DSCP_W-1:0]     dscp_o,
  output logic                              last_o
);

  localparam int unsigned BlenW  = rtpfua_pkg::BLEN_W;
  localparam int unsigned PlenW  = rtpfua_pkg::PLEN_W;
  localparam int unsigned DscpW  = rtpfua_pkg::DSCP_W;
  // Fragment count times fragment size, compared against the NAL data length
  localparam int unsigned FcntW  = $clog2(MAX_FRAGMENTS + 1);
  localparam int unsigned ProdW  = FcntW + PlenW;
  localparam int unsigned OvrW   = (ProdW > BlenW) ? ProdW : BlenW;
  // Width wide enough for both the limit register and the payload ceiling
  localparam int unsigned CeilW0 = $clog2(MAX_PACKET_PAYLOAD + 1);
  localparam int unsigned LimCmpW = ((CeilW0 > PlenW) ? CeilW0 : PlenW) + 1;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PlenW-1:0] max_payload_q;
  logic [DscpW-1:0] dscp_ref_q;
  logic [DscpW-1:0] dscp_other_q;
  logic [1:0]       reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= rtpfua_pkg::MAX_PAYLOAD_RST;
      dscp_ref_q    <= rtpfua_pkg::DSCP_REF_RST;
      dscp_other_q  <= rtpfua_pkg::DSCP_OTHER_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        rtpfua_pkg::REG_MAX_PAYLOAD: max_payload_q <= pwdata[PlenW-1:0];
        rtpfua_pkg::REG_DSCP_REF:    dscp_ref_q    <= pwdata[DscpW-1:0];
        rtpfua_pkg::REG_DSCP_OTHER:  dscp_other_q  <= pwdata[DscpW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rtpfua_pkg::REG_MAX_PAYLOAD: prdata = rtpfua_pkg::DATA_W'(max_payload_q);
      rtpfua_pkg::REG_DSCP_REF:    prdata = rtpfua_pkg::DATA_W'(dscp_ref_q);
      rtpfua_pkg::REG_DSCP_OTHER:  prdata = rtpfua_pkg::DATA_W'(dscp_other_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input decode: start code strip, NAL header, type gate, payload limit
  // ---------------------------------------------------------------------------
  logic [1:0]       state_q, state_d;
  logic [2:0]       marks_q;
  logic             in_xfer;
  logic             strip;
  logic [7:0]       nal_hdr;
  logic [4:0]       nal_type;
  logic [BlenW-1:0] nal_len;
  logic [2:0]       need;
  logic [2:0]       mark;
  logic             known;
  logic             pass;
  logic [LimCmpW-1:0] mpl_ext;
  logic [PlenW-1:0] limit;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_xfer    = in_valid_i & in_ready_o;

  assign strip    = (buffer_len_i >= BlenW'(5)) && (lead_bytes_i[39:8] == 32'd1);
  assign nal_hdr  = strip ? lead_bytes_i[7:0] : lead_bytes_i[39:32];
  assign nal_type = nal_hdr[4:0];
  assign nal_len  = strip ? buffer_len_i - BlenW'(4) : buffer_len_i;

  always_comb begin
    known = 1'b1;
    need  = '0;
    mark  = '0;
    case (nal_type)
      rtpfua_pkg::NAL_SPS:    mark = rtpfua_pkg::MARK_SPS;
      rtpfua_pkg::NAL_PPS:    mark = rtpfua_pkg::MARK_PPS;
      rtpfua_pkg::NAL_IDR: begin
        need = rtpfua_pkg::MARK_SPS | rtpfua_pkg::MARK_PPS;
        mark = rtpfua_pkg::MARK_IDR;
      end
      rtpfua_pkg::NAL_NONIDR: need = rtpfua_pkg::MARK_IDR;
      default:                known = 1'b0;
    endcase
  end

  // Drop empty buffers, unsupported types and types whose prerequisites are missing
  assign pass = (buffer_len_i != '0) && known && ((marks_q & need) == need);

  // Saturate the payload limit to the supported range
  assign mpl_ext = LimCmpW'(max_payload_q);
  always_comb begin
    if (max_payload_q < PlenW'(rtpfua_pkg::MIN_PAYLOAD)) begin
      limit = PlenW'(rtpfua_pkg::MIN_PAYLOAD);
    end else if (mpl_ext > LimCmpW'(MAX_PACKET_PAYLOAD)) begin
      limit = PlenW'(MAX_PACKET_PAYLOAD);
    end else begin
      limit = max_payload_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-item context
  // ---------------------------------------------------------------------------
  logic [7:0]       hdr_q;
  logic             eof_q;
  logic [DscpW-1:0] dscp_q;
  logic [2:0]       mark_q;
  logic             short_q;
  logic             over_q;
  logic [PlenW-1:0] limit_q;
  logic [PlenW-1:0] frag;
  logic [BlenW-1:0] base_len_q;
  logic [BlenW-1:0] base_off_q;
  logic [BlenW-1:0] rem_q, rem_d;
  logic [BlenW-1:0] off_q, off_d;
  logic             first_q, first_d;
  logic [ProdW-1:0] cap;

  assign frag = limit_q - PlenW'(2);
  assign cap  = ProdW'(MAX_FRAGMENTS) * ProdW'(frag);

  // Timestamp dividend: us * 9, formed as a shift and an add
  logic [rtpfua_pkg::TS_NUM_W-1:0] ts_num;
  rtpfua_pkg::div_status_t         div_st;

  assign ts_num = rtpfua_pkg::TS_NUM_W'({timestamp_us_i, 3'b000})
                + rtpfua_pkg::TS_NUM_W'(timestamp_us_i);

  rtpfua_tsdiv u_tsdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer & pass),
    .dividend_i (ts_num),
    .status_o   (div_st)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer && pass) begin
      hdr_q      <= nal_hdr;
      eof_q      <= end_of_frame_i;
      dscp_q     <= (nal_type == rtpfua_pkg::NAL_NONIDR) ? dscp_ref_q : dscp_other_q;
      mark_q     <= mark;
      short_q    <= nal_len < BlenW'(limit);
      limit_q    <= limit;
      base_len_q <= nal_len;
      base_off_q <= strip ? BlenW'(4) : '0;
    end
    // Settle the oversize check while the divider runs
    if (state_q == ST_DIV) begin
      over_q <= OvrW'(rem_q) > OvrW'(cap);
    end
  end

  // ---------------------------------------------------------------------------
  // Result generation and output register
  // ---------------------------------------------------------------------------
  logic             out_valid_q, out_valid_d;
  logic             load;
  logic             frag_last;
  logic [PlenW-1:0] frag_len;
  logic             r_status;
  logic [BlenW-1:0] r_off;
  logic [PlenW-1:0] r_len;
  logic             r_fu;
  logic [7:0]       r_ind;
  logic [7:0]       r_hdr;
  logic             r_marker;
  logic [DscpW-1:0] r_dscp;
  logic             r_last;

  assign load      = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign frag_last = rem_q <= BlenW'(frag);
  assign frag_len  = frag_last ? rem_q[PlenW-1:0] : frag;

  always_comb begin
    r_status = 1'b0;
    r_off    = '0;
    r_len    = '0;
    r_fu     = 1'b0;
    r_ind    = '0;
    r_hdr    = '0;
    r_marker = 1'b0;
    r_dscp   = '0;
    r_last   = 1'b1;
    if (short_q) begin
      // Single NAL unit packet
      r_off    = base_off_q;
      r_len    = base_len_q[PlenW-1:0];
      r_marker = eof_q;
      r_dscp   = dscp_q;
    end else if (over_q) begin
      // Too many fragments: one error result with last set, everything else zero
      r_status = 1'b1;
    end else begin
      r_off    = off_q;
      r_len    = frag_len;
      r_fu     = 1'b1;
      r_ind    = {hdr_q[7:5], rtpfua_pkg::NAL_FU_A};
      r_hdr    = {3'b000, hdr_q[4:0]}
               | (first_q ? rtpfua_pkg::FU_START : 8'h00)
               | (frag_last ? rtpfua_pkg::FU_END : 8'h00);
      r_marker = eof_q & frag_last;
      r_dscp   = dscp_q;
      r_last   = frag_last;
    end
  end

  // Sequencer: idle, wait on the divider, then emit one result per transfer slot
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    off_d   = off_q;
    first_d = first_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && pass) begin
          state_d = ST_DIV;
          rem_d   = nal_len - BlenW'(1);
          off_d   = (strip ? BlenW'(4) : '0) + BlenW'(1);
          first_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          // advance to the next fragment
          off_d   = off_q + BlenW'(frag_len);
          rem_d   = rem_q - BlenW'(frag_len);
          first_d = 1'b0;
          if (r_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      marks_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      // record the type as sent unless the NAL is dropped as oversize
      if (state_q == ST_DIV && div_st.done && (short_q || !over_q)) begin
        marks_q <= marks_q | mark_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    off_q   <= off_d;
    first_q <= first_d;
    if (load) begin
      status_o         <= r_status;
      payload_offset_o <= r_off;
      payload_len_o    <= r_len;
      has_fu_header_o  <= r_fu;
      fu_indicator_o   <= r_ind;
      fu_header_o      <= r_hdr;
      marker_o         <= r_marker;
      rtp_timestamp_o  <= r_status ? '0 : div_st.quotient;
      dscp_o           <= r_dscp;
      last_o           <= r_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
